// ===== sv/rrw_pkg.sv =====
// ----------------------------------------------------------------------------
// rrw_pkg
// shared constants, register codes and sequencer states of the rescaled range
// window block
// ----------------------------------------------------------------------------
package rrw_pkg;

    localparam int MAX_SAMPLES_DEF = 512;
    localparam int PRICE_BITS_DEF  = 24;

    localparam int WL_BITS    = 9;
    localparam int N_BITS     = 10;
    localparam int SEEN_BITS  = 10;
    localparam int RATIO_BITS = 32;
    localparam int FRAC_BITS  = 16;

    localparam logic [WL_BITS-1:0] WL_RESET = 9'd200;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // register indexes (paddr[2])
    localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS1,
        S_PASS2,
        S_MUL,
        S_SQR,
        S_ROOT,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== sv/rrw_price_if.sv =====
// ----------------------------------------------------------------------------
// rrw_price_if
// request channel carrying one closing price
// ----------------------------------------------------------------------------
interface rrw_price_if #(
    parameter int PRICE_BITS = rrw_pkg::PRICE_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] close_price;

    modport source (output valid, output close_price, input ready);
    modport sink   (input valid, input close_price, output ready);
endinterface

// ===== sv/rrw_ratio_if.sv =====
// ----------------------------------------------------------------------------
// rrw_ratio_if
// result channel carrying one rescaled range ratio
// ----------------------------------------------------------------------------
interface rrw_ratio_if ();
    logic                            valid;
    logic                            ready;
    logic [rrw_pkg::RATIO_BITS-1:0]  rs_ratio;

    modport source (output valid, output rs_ratio, input ready);
    modport sink   (input valid, input rs_ratio, output ready);
endinterface

// ===== sv/rrw_ring.sv =====
// ----------------------------------------------------------------------------
// rrw_ring
// sample ring memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module rrw_ring #(
    parameter int DEPTH  = rrw_pkg::MAX_SAMPLES_DEF,
    parameter int WIDTH  = rrw_pkg::PRICE_BITS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/rrw_apb.sv =====
// ----------------------------------------------------------------------------
// rrw_apb
// apb register port holding the window length
// ----------------------------------------------------------------------------
module rrw_apb (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rrw_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [rrw_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [rrw_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    output logic [rrw_pkg::WL_BITS-1:0]       o_window_length
);

    logic [rrw_pkg::WL_BITS-1:0] r_wl;
    logic [rrw_pkg::WL_BITS-1:0] n_wl;
    logic                        hit;

    assign hit    = (paddr[rrw_pkg::APB_ADDR_BITS-1:2] == rrw_pkg::REG_WINDOW_LENGTH);
    assign pready = 1'b1;

    always_comb begin
        n_wl = r_wl;
        if (psel && penable && pwrite && hit) begin
            n_wl = pwdata[rrw_pkg::WL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= rrw_pkg::WL_RESET;
        end else begin
            r_wl <= n_wl;
        end
    end

    assign prdata = hit ? {{(rrw_pkg::APB_DATA_BITS-rrw_pkg::WL_BITS){1'b0}}, r_wl}
                        : '0;
    assign o_window_length = r_wl;

endmodule

// ===== sv/rescaled_range_window.sv =====
// ----------------------------------------------------------------------------
// rescaled_range_window
// rescaled range (r/s) ratio over a sliding window of closing prices
// ----------------------------------------------------------------------------
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+------------------------------------
//  i_price   | in  | valid/ready           | close_price, PRICE_BITS unsigned
//  o_ratio   | out | valid/ready           | rs_ratio, 32 bit unsigned q16.16
//  apb       | in  | psel/penable, pready  | window_length at byte address 0
//
//  a request that yields no ratio leaves the sequencer idle; otherwise the
//  run is set by the two ring walks over n = window length + 1 samples (one
//  read a cycle) and the bit-serial multiply, root and divide steps
//  reset is synchronous; the ring needs no clearing, only control state resets
//  a finished ratio waits in the output register; a new request is taken while
//  it waits, and the sequencer holds in its done state if the ratio is unread
// ----------------------------------------------------------------------------
module rescaled_range_window #(
    parameter int MAX_SAMPLES = rrw_pkg::MAX_SAMPLES_DEF,
    parameter int PRICE_BITS  = rrw_pkg::PRICE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rrw_price_if.sink                         i_price,
    rrw_ratio_if.source                       o_ratio,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rrw_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [rrw_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [rrw_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);

    localparam int P      = PRICE_BITS;
    localparam int NB     = rrw_pkg::N_BITS;
    localparam int PTR_W  = $clog2(MAX_SAMPLES);
    localparam int MW     = (P > NB) ? P : NB;     // multiplier operand width
    localparam int SW     = P + 9;                 // sum of window
    localparam int QW     = 2 * P + 9;             // sum of squares
    localparam int RW     = P + 10;                // square root width
    localparam int AW     = 2 * RW;                // wide accumulator
    localparam int DW     = P + 10;                // signed deviation
    localparam int YW     = P + 19;                // signed running sum
    localparam int FB     = rrw_pkg::FRAC_BITS;
    localparam int OB     = rrw_pkg::RATIO_BITS;
    localparam int STEP_MAX = (RW > OB) ? RW : OB;
    localparam int STEP_W = $clog2(STEP_MAX + 1);
    localparam int CW     = ((PTR_W > NB) ? PTR_W : NB) + 1;
    localparam int WCAP_I = (MAX_SAMPLES - 1 < 511) ? MAX_SAMPLES - 1 : 511;
    localparam logic [NB-1:0] WCAP = NB'(WCAP_I);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_SAMPLES - 1);
    localparam logic [rrw_pkg::SEEN_BITS-1:0] SEEN_MAX = '1;

    // configuration
    logic [rrw_pkg::WL_BITS-1:0] window_length;

    rrw_apb u_apb (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_window_length (window_length)
    );

    // sequencer and datapath registers
    rrw_pkg::t_state   r_state, n_state;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [rrw_pkg::SEEN_BITS-1:0] r_seen, n_seen;
    logic [NB-1:0]     r_n, n_n;
    logic [PTR_W-1:0]  r_start, n_start;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [NB-1:0]     r_cnt, n_cnt;
    logic              r_rd_v, n_rd_v;
    logic              r_p_v, n_p_v;
    logic              r_b_v, n_b_v;
    logic [2*MW-1:0]   r_prod, n_prod;
    logic [SW-1:0]     r_sum, n_sum;
    logic [QW-1:0]     r_q, n_q;
    logic signed [DW-1:0] r_d, n_d;
    logic signed [YW-1:0] r_y, n_y;
    logic signed [YW-1:0] r_ymin, n_ymin;
    logic signed [YW-1:0] r_ymax, n_ymax;
    logic [YW-1:0]     r_range, n_range;
    logic [AW-1:0]     r_acc, n_acc;
    logic [AW-1:0]     r_mcand, n_mcand;
    logic [SW-1:0]     r_mplier, n_mplier;
    logic [RW-1:0]     r_root, n_root;
    logic [RW+1:0]     r_rem, n_rem;
    logic [OB-1:0]     r_num, n_num;
    logic [OB-1:0]     r_quo, n_quo;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_v, n_out_v;
    logic [OB-1:0]     r_ratio, n_ratio;

    // combinational helpers
    logic              accept;
    logic [P-1:0]      rd_data;
    logic              rd_en;
    logic [2*MW-1:0]   mul_p;
    logic [NB-1:0]     w_eff;
    logic [NB-1:0]     n_new;
    logic [PTR_W-1:0]  wp_next;
    logic [rrw_pkg::SEEN_BITS-1:0] seen_next;
    logic [CW-1:0]     wp_ext;
    logic [CW-1:0]     n_ext;
    logic signed [YW-1:0] y_nx;
    logic [RW+1:0]     rem_sh;
    logic [RW+1:0]     trial;
    logic [RW:0]       dsh;
    logic [RW:0]       dvs;
    logic [RW-1:0]     range_hi;

    assign accept = i_price.valid && i_price.ready;
    assign i_price.ready = (r_state == rrw_pkg::S_IDLE);

    rrw_ring #(
        .DEPTH  (MAX_SAMPLES),
        .WIDTH  (P),
        .ADDR_W (PTR_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_wp),
        .i_wr_data (i_price.close_price),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (rd_data)
    );

    // shared multiplier: x*x on the first walk, n*x on the second
    assign mul_p = MW'(rd_data) * ((r_state == rrw_pkg::S_PASS1) ? MW'(rd_data) : MW'(r_n));

    // window clamp and start slot of the newest n samples
    assign w_eff     = ({1'b0, window_length} > WCAP) ? WCAP : {1'b0, window_length};
    assign n_new     = w_eff + 1'b1;
    assign wp_next   = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign seen_next = (r_seen == SEEN_MAX) ? r_seen : r_seen + 1'b1;
    assign wp_ext    = CW'(wp_next);
    assign n_ext     = CW'(n_new);

    assign y_nx     = r_y + YW'(r_d);
    assign rem_sh   = {r_rem[RW-1:0], r_acc[AW-1 -: 2]};
    assign trial    = {r_root, 2'b01};
    assign dsh      = {r_rem[RW-1:0], r_num[OB-1]};
    assign dvs      = {1'b0, r_root};
    assign range_hi = RW'(r_range[YW-1:FB]);

    always_comb begin
        n_state  = r_state;
        n_wp     = r_wp;
        n_seen   = r_seen;
        n_n      = r_n;
        n_start  = r_start;
        n_ptr    = r_ptr;
        n_cnt    = r_cnt;
        n_rd_v   = 1'b0;
        n_p_v    = 1'b0;
        n_b_v    = 1'b0;
        n_prod   = r_prod;
        n_sum    = r_sum;
        n_q      = r_q;
        n_d      = r_d;
        n_y      = r_y;
        n_ymin   = r_ymin;
        n_ymax   = r_ymax;
        n_range  = r_range;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_root   = r_root;
        n_rem    = r_rem;
        n_num    = r_num;
        n_quo    = r_quo;
        n_step   = r_step;
        n_out_v  = r_out_v;
        n_ratio  = r_ratio;
        rd_en    = 1'b0;

        // result taken downstream
        if (r_out_v && o_ratio.ready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            rrw_pkg::S_IDLE: begin
                if (accept) begin
                    n_wp   = wp_next;
                    n_seen = seen_next;
                    // enough history for a full window plus margin
                    if ({1'b0, seen_next} > (11'(w_eff) + 11'd2)) begin
                        n_n     = n_new;
                        n_start = (wp_ext >= n_ext) ? PTR_W'(wp_ext - n_ext)
                                : PTR_W'(wp_ext + CW'(MAX_SAMPLES) - n_ext);
                        n_ptr   = n_start;
                        n_cnt   = '0;
                        n_sum   = '0;
                        n_q     = '0;
                        n_state = rrw_pkg::S_PASS1;
                    end
                end
            end

            rrw_pkg::S_PASS1, rrw_pkg::S_PASS2: begin
                // read one ring slot a cycle
                if (r_cnt != r_n) begin
                    rd_en  = 1'b1;
                    n_ptr  = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_rd_v = 1'b1;
                end
                // stage a: product, and the plain sum on the first walk
                n_p_v = r_rd_v;
                if (r_rd_v) begin
                    n_prod = mul_p;
                    if (r_state == rrw_pkg::S_PASS1) begin
                        n_sum = r_sum + SW'(rd_data);
                    end
                end
                // stage b: square sum, or deviation d = n*x - sum
                n_b_v = r_p_v && (r_state == rrw_pkg::S_PASS2);
                if (r_p_v) begin
                    if (r_state == rrw_pkg::S_PASS1) begin
                        n_q = r_q + QW'(r_prod[2*P-1:0]);
                    end else begin
                        n_d = $signed({1'b0, r_prod[SW-1:0]}) - $signed({1'b0, r_sum});
                    end
                end
                // stage c: running sum and its extremes
                if (r_b_v) begin
                    n_y = y_nx;
                    if (y_nx < r_ymin) begin
                        n_ymin = y_nx;
                    end
                    if (y_nx > r_ymax) begin
                        n_ymax = y_nx;
                    end
                end
                // walk finished and pipe drained
                if ((r_cnt == r_n) && !r_rd_v && !r_p_v && !r_b_v) begin
                    if (r_state == rrw_pkg::S_PASS1) begin
                        n_ptr   = r_start;
                        n_cnt   = '0;
                        n_y     = '0;
                        n_ymin  = '0;
                        n_ymax  = '0;
                        n_state = rrw_pkg::S_PASS2;
                    end else begin
                        n_range  = r_ymax - r_ymin;
                        n_acc    = '0;
                        n_mcand  = AW'(r_q);
                        n_mplier = SW'(r_n);
                        n_state  = rrw_pkg::S_MUL;
                    end
                end
            end

            rrw_pkg::S_MUL: begin
                // acc = n * sum of squares, shift-add
                if (r_mplier == '0) begin
                    n_mcand  = AW'(r_sum);
                    n_mplier = r_sum;
                    n_state  = rrw_pkg::S_SQR;
                end else begin
                    if (r_mplier[0]) begin
                        n_acc = r_acc + r_mcand;
                    end
                    n_mcand  = r_mcand << 1;
                    n_mplier = r_mplier >> 1;
                end
            end

            rrw_pkg::S_SQR: begin
                // acc -= sum^2, leaving t = sum(d^2) / n exactly
                if (r_mplier == '0) begin
                    n_root  = '0;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = rrw_pkg::S_ROOT;
                end else begin
                    if (r_mplier[0]) begin
                        n_acc = r_acc - r_mcand;
                    end
                    n_mcand  = r_mcand << 1;
                    n_mplier = r_mplier >> 1;
                end
            end

            rrw_pkg::S_ROOT: begin
                if (r_step == STEP_W'(RW)) begin
                    n_step = '0;
                    if (r_root == '0) begin
                        // zero spread
                        n_quo   = '0;
                        n_state = rrw_pkg::S_DONE;
                    end else if (range_hi >= r_root) begin
                        // ratio of 2^16 or more, beyond the q16.16 range
                        n_quo   = '1;
                        n_state = rrw_pkg::S_DONE;
                    end else begin
                        n_rem   = (RW+2)'(range_hi);
                        n_num   = {r_range[FB-1:0], {(OB-FB){1'b0}}};
                        n_quo   = '0;
                        n_state = rrw_pkg::S_DIV;
                    end
                end else begin
                    // one root bit a cycle
                    if (rem_sh >= trial) begin
                        n_rem  = rem_sh - trial;
                        n_root = {r_root[RW-2:0], 1'b1};
                    end else begin
                        n_rem  = rem_sh;
                        n_root = {r_root[RW-2:0], 1'b0};
                    end
                    n_acc  = r_acc << 2;
                    n_step = r_step + 1'b1;
                end
            end

            rrw_pkg::S_DIV: begin
                if (r_step == STEP_W'(OB)) begin
                    n_state = rrw_pkg::S_DONE;
                end else begin
                    // one quotient bit a cycle
                    if (dsh >= dvs) begin
                        n_rem = (RW+2)'(dsh - dvs);
                        n_quo = {r_quo[OB-2:0], 1'b1};
                    end else begin
                        n_rem = (RW+2)'(dsh);
                        n_quo = {r_quo[OB-2:0], 1'b0};
                    end
                    n_num  = r_num << 1;
                    n_step = r_step + 1'b1;
                end
            end

            rrw_pkg::S_DONE: begin
                if (!r_out_v || o_ratio.ready) begin
                    n_ratio = r_quo;
                    n_out_v = 1'b1;
                    n_state = rrw_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = rrw_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrw_pkg::S_IDLE;
            r_wp    <= '0;
            r_seen  <= '0;
            r_cnt   <= '0;
            r_n     <= '0;
            r_rd_v  <= 1'b0;
            r_p_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_seen  <= n_seen;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_rd_v  <= n_rd_v;
            r_p_v   <= n_p_v;
            r_b_v   <= n_b_v;
            r_out_v <= n_out_v;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_ptr    <= n_ptr;
        r_prod   <= n_prod;
        r_sum    <= n_sum;
        r_q      <= n_q;
        r_d      <= n_d;
        r_y      <= n_y;
        r_ymin   <= n_ymin;
        r_ymax   <= n_ymax;
        r_range  <= n_range;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_root   <= n_root;
        r_rem    <= n_rem;
        r_num    <= n_num;
        r_quo    <= n_quo;
        r_step   <= n_step;
        r_ratio  <= n_ratio;
    end

    assign o_ratio.valid    = r_out_v;
    assign o_ratio.rs_ratio = r_ratio;

    // pipe is empty whenever the sequencer rests
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrw_pkg::S_IDLE) |-> (!r_rd_v && !r_p_v && !r_b_v))
        else $error("walk pipe not drained in idle");

    // never read past the window
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == rrw_pkg::S_PASS1) || (r_state == rrw_pkg::S_PASS2)) |-> (r_cnt <= r_n))
        else $error("ring walk overran window");

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rrw_pkg::S_DIV) |-> (r_rem < (RW+2)'(r_root)))
        else $error("divide remainder out of range");

    // a result appears only from the done state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> ($past(r_state) == rrw_pkg::S_DONE))
        else $error("result raised outside done state");

endmodule

// ===== dv/rescaled_range_window_tb.sv =====
// ----------------------------------------------------------------------------
// rescaled_range_window_tb
// self-checking bench for the rescaled range window: directed price table,
// then random price streams over several window lengths, each ratio checked
// against a behavioral r/s predictor, with random idling and a long hold-off
// ----------------------------------------------------------------------------
module rescaled_range_window_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = rrw_pkg::MAX_SAMPLES_DEF;
    localparam int PB   = rrw_pkg::PRICE_BITS_DEF;
    localparam longint CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [rrw_pkg::APB_ADDR_BITS-1:0] paddr = '0;
    logic [rrw_pkg::APB_DATA_BITS-1:0] pwdata = '0;
    logic [rrw_pkg::APB_DATA_BITS-1:0] prdata;
    logic pready;

    rrw_price_if #(.PRICE_BITS(PB)) price_ch ();
    rrw_ratio_if ratio_ch ();

    rescaled_range_window i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_price(price_ch.sink),
        .o_ratio(ratio_ch.source), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state: a copy of the ring, pointer, count and window length
    logic [PB-1:0]      price_ring [RING];
    logic [8:0]         ring_wptr;
    logic [9:0]         seen_cnt;
    logic [rrw_pkg::WL_BITS-1:0] win_len;
    logic [31:0]        ratio_queue [$];

    int  err_cnt = 0;
    int  ratio_cnt = 0;
    int  req_cnt = 0;
    bit  idle_on = 1'b1;
    bit  hold_off = 1'b0;
    longint cycle_cnt = 0;

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // r/s over the newest n samples, exact integer arithmetic scaled by n
    function automatic logic [31:0] rs_ratio_of(input int n);
        logic signed [63:0] sum, d, y, ymin, ymax;
        logic [127:0] sq, t, num;
        logic [63:0] range, root, c;
        logic [31:0] q;
        int p;
        sum = 0; y = 0; ymin = 0; ymax = 0; sq = 0; root = 0; q = 0;
        p = (int'(ring_wptr) + RING - n) % RING;
        for (int i = 0; i < n; i++) sum += $signed({40'd0, price_ring[9'((p + i) % RING)]});
        for (int i = 0; i < n; i++) begin
            d = 64'(n) * $signed({40'd0, price_ring[9'((p + i) % RING)]}) - sum;
            y += d;
            if (y < ymin) ymin = y;
            if (y > ymax) ymax = y;
            sq += 128'(d < 0 ? -d : d) * 128'(d < 0 ? -d : d);
        end
        range = ymax - ymin;
        t = sq / 128'(n);
        for (int b = 63; b >= 0; b--) begin
            c = root | (64'd1 << b);
            if (128'(c) * 128'(c) <= t) root = c;
        end
        if (root == 64'd0) return 32'd0;
        num = 128'(range) << 16;
        if ((128'(root) << 32) <= num) return 32'hFFFF_FFFF;
        return 32'(num / 128'(root));
    endfunction

    // advance the predictor by one price; returns 1 when a ratio is due
    function automatic bit price_step(input logic [PB-1:0] px, output logic [31:0] r);
        int w;
        price_ring[ring_wptr] = px;
        ring_wptr = ring_wptr + 1'b1;
        if (seen_cnt != 10'd1023) seen_cnt = seen_cnt + 1'b1;
        w = (int'(win_len) > RING - 1) ? RING - 1 : int'(win_len);
        r = '0;
        if (int'(seen_cnt) <= w + 2) return 1'b0;
        r = rs_ratio_of(w + 1);
        return 1'b1;
    endfunction

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random ready bursts, long hold-off when asked
    int rdy_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ratio_ch.ready <= 1'b0;
        end else begin
            if (ratio_ch.valid && ratio_ch.ready) begin
                ratio_cnt++;
                if (ratio_queue.size() == 0) begin
                    report("unexpected ratio", ratio_ch.rs_ratio, 32'd0);
                end else begin
                    logic [31:0] want;
                    want = ratio_queue.pop_front();
                    if (ratio_ch.rs_ratio !== want) report("rs_ratio", ratio_ch.rs_ratio, want);
                end
            end
            if (hold_off) begin
                ratio_ch.ready <= 1'b0;
            end else if (rdy_gap > 0) begin
                rdy_gap--;
                ratio_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rdy_gap = $urandom_range(0, 2);
                ratio_ch.ready <= 1'b0;
            end else begin
                ratio_ch.ready <= 1'b1;
            end
        end
    end

    // holds the result side off for a long stretch, counted in cycles
    task automatic hold_results(input int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    // offers one price, with optional idle burst before it, until accepted
    task automatic send_price(input logic [PB-1:0] px, input logic has_want,
                              input logic [31:0] typed_want);
        logic [31:0] r;
        bit due;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            price_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        price_ch.valid <= 1'b1;
        price_ch.close_price <= px;
        do @(posedge i_clk); while (!price_ch.ready);
        due = price_step(px, r);
        if (due) begin
            // a typed value must agree with the predictor as well
            if (has_want && typed_want !== r) report("table row", r, typed_want);
            ratio_queue.push_back(has_want ? typed_want : r);
        end
        req_cnt++;
    endtask

    task automatic end_stream();
        price_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // waits for every ratio, then for the longest ratio latency
    task automatic drain();
        while (ratio_queue.size() != 0) @(posedge i_clk);
        repeat (2 * RING + 2 * PB + 200) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [rrw_pkg::WL_BITS-1:0] wl);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {rrw_pkg::REG_WINDOW_LENGTH, 2'b00};
        pwdata <= 32'(wl);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        win_len = wl;
        @(posedge i_clk);
    endtask

    // directed rows: price plus a typed ratio where obvious
    typedef struct {
        logic [PB-1:0] px;
        logic          has_want;
        logic [31:0]   want;
    } t_row;

    t_row dir_rows [$];

    task automatic random_phase(input int count, input int max_px);
        logic [PB-1:0] base, px;
        base = PB'($urandom_range(0, max_px));
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0:       px = PB'($urandom);                 // noise
                1:       px = ($urandom_range(0, 1)) ? '1 : '0; // extremes
                2:       px = base;                            // flat run
                default: begin                                 // random walk
                    base = base + PB'($signed($urandom_range(0, 2000)) - 1000);
                    px = base;
                end
            endcase
            send_price(px, 1'b0, 32'd0);
        end
    endtask

    initial begin
        logic [31:0] rb;
        price_ch.valid = 1'b0;
        price_ch.close_price = '0;
        ring_wptr = '0;
        seen_cnt = '0;
        win_len = rrw_pkg::WL_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value readback
        psel <= 1'b1; pwrite <= 1'b0; paddr <= '0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rb = prdata;
        psel <= 1'b0; penable <= 1'b0;
        if (rb[rrw_pkg::WL_BITS-1:0] !== rrw_pkg::WL_RESET) begin
            report("window reset", rb, 32'(rrw_pkg::WL_RESET));
        end
        @(posedge i_clk);

        // window length 2: flat prices give zero spread, then extremes
        write_window(9'd2);
        for (int i = 0; i < 6; i++) dir_rows.push_back('{PB'(1234), 1'b1, 32'd0});
        for (int i = 0; i < 4; i++) dir_rows.push_back('{'0, 1'b0, 32'd0});
        for (int i = 0; i < 4; i++) dir_rows.push_back('{'1, 1'b0, 32'd0});
        dir_rows.push_back('{'0, 1'b0, 32'd0});
        dir_rows.push_back('{'1, 1'b0, 32'd0});
        dir_rows.push_back('{'0, 1'b0, 32'd0});
        dir_rows.push_back('{'1, 1'b0, 32'd0});
        for (int i = 0; i < 4; i++) dir_rows.push_back('{PB'(i * 4097 + 5), 1'b0, 32'd0});
        foreach (dir_rows[k]) send_price(dir_rows[k].px, dir_rows[k].has_want, dir_rows[k].want);
        end_stream();
        drain();

        // pressure: results held off while prices keep coming
        write_window(9'd3);
        fork
            hold_results(3000);
            random_phase(20, 1 << 20);
        join
        end_stream();
        drain();

        // a few settings, mostly small, one at the top of the range
        write_window(9'd7);
        random_phase(60, (1 << PB) - 1);
        end_stream();
        drain();

        write_window(9'd511);
        random_phase(25, (1 << PB) - 1);
        end_stream();
        drain();

        write_window(9'd30);
        random_phase(70, 1 << 16);
        end_stream();
        drain();

        // last part without idling
        idle_on = 1'b0;
        write_window(9'd2);
        random_phase(90, (1 << PB) - 1);
        end_stream();
        drain();

        $display("tb: %0d prices sent, %0d ratios checked, window lengths 2 to 511 programmed",
                 req_cnt, ratio_cnt);
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
